// ===== hdl/clp_pkg.sv =====
// Shared widths, codes and channel payload types of the crossfaded loop player.
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LOOP_DEPTH_DEF = 1048576;
    localparam int GAIN_TABLE_DEPTH_DEF = 1024;

    // Q1.15 gains; unity is 32768 and still fits 16 unsigned bits
    localparam int GAIN_W = 16;
    localparam int UNITY_Q15 = 32768;

    // seam length, divisor (xf + 1), quotient and dividend widths
    localparam int XF_W = 14;
    localparam int DEN_W = XF_W + 1;
    localparam int QW = 15;
    localparam int NUM_W = DEN_W + QW;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROSSFADE_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_FADE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_CHANNELS = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]              cmd;
        logic [19:0]                   write_addr;
        logic signed [SAMPLE_BITS-1:0] dry_left;
        logic signed [SAMPLE_BITS-1:0] dry_right;
    } clp_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic                          in_seam;
    } clp_result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } clp_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/clp_stream_if.sv =====
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none

interface clp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/clp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the seam gain position.
`timescale 1ns / 1ps
`default_nettype none

module clp_div
    import clp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [QW-1:0]         quot
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QW-1:0]    work_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    // shift in the next dividend bit and try to subtract
    assign trial = {rem_reg, work_reg[QW-1]};
    assign fits = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // the upper dividend bits stay below the divisor, so QW steps suffice
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QW];
            work_reg <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
            end
            work_reg <= {work_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

`default_nettype wire

// ===== hdl/clp_gain_rom.sv =====
// Quarter-sine gain table in Q1.15, built at elaboration, registered read.
`timescale 1ns / 1ps
`default_nettype none

module clp_gain_rom
    import clp_pkg::*;
#(
    parameter int GAIN_TABLE_DEPTH = GAIN_TABLE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rd,
    input  wire logic [$clog2(GAIN_TABLE_DEPTH)-1:0] addr,
    output logic [GAIN_W-1:0]                        gain
);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ANGLE_DIV = 64'(2 * GAIN_TABLE_DEPTH);
    localparam longint unsigned TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Q30 Taylor series of sin at the middle of entry i, rounded to Q15
    function automatic logic [GAIN_W-1:0] sine_entry(input longint unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        int              n;
        x = (HALF_PI_Q30 * (64'd2 * i + 64'd1)) / ANGLE_DIV;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (n = 0; n < 8; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd16384) >> 15;
        if (r > 64'(UNITY_Q15))
        begin
            r = 64'(UNITY_Q15);
        end
        return GAIN_W'(r);
    endfunction

    function automatic logic [GAIN_TABLE_DEPTH-1:0][GAIN_W-1:0] build_table();
        logic [GAIN_TABLE_DEPTH-1:0][GAIN_W-1:0] tab;
        int                                      i;
        tab = '0;
        for (i = 0; i < GAIN_TABLE_DEPTH; i++)
        begin
            tab[i] = sine_entry(64'(i));
        end
        return tab;
    endfunction

    localparam logic [GAIN_TABLE_DEPTH-1:0][GAIN_W-1:0] GAIN_TABLE = build_table();

    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            gain_reg <= GAIN_TABLE[addr];
        end
    end

    assign gain = gain_reg;

endmodule

`default_nettype wire

// ===== hdl/crossfaded_loop_playback.sv =====
// Top level of the crossfaded stereo loop player.
//
// Channels: item (sink) carries cmd, write_addr, dry_left, dry_right; result
// (source) carries out_left, out_right, in_seam; cfg (sink, always ready)
// writes one register per beat by index.
// A write beat stores a stereo pair in the loop store if write_addr is below
// the loop depth; a restart beat moves the play position; neither gives a
// result. A tick beat gives one result. With playback off or an empty loop
// the dry beat passes through the load state into the output register. A
// loop sample outside the seam takes two store reads, then one shared 17x26
// multiplier runs the wet/dry mix for each channel. In the seam a 15-step
// divider first finds the gain position, and the same multiplier blends the
// head and tail samples of each channel before the mix.
// item.ready is high only while no tick is in progress. The next beat is
// taken while a finished result still waits in the output register; a tick
// stalls in its last cycle until that register frees up.
// Reset returns the registers to their defaults and the play position to 0.
// The loop store is not cleared: play only what was written.
`timescale 1ns / 1ps
`default_nettype none

module crossfaded_loop_playback
    import clp_pkg::*;
#(
    parameter int LOOP_DEPTH = LOOP_DEPTH_DEF,
    parameter int GAIN_TABLE_DEPTH = GAIN_TABLE_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    clp_stream_if.sink   item,
    clp_stream_if.source result,
    clp_stream_if.sink   cfg
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(LOOP_DEPTH);
    localparam int LEN_W = $clog2(LOOP_DEPTH + 1);
    localparam int IW = $clog2(GAIN_TABLE_DEPTH);
    localparam int WORD_W = 2 * SB;
    localparam int WET_W = SB + 1;
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = SB + 2;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int BLEND_W = PROD_W + 1;
    localparam int MIXV_W = SB + 4;
    localparam logic signed [MIXV_W-1:0] SAT_HI = MIXV_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [MIXV_W-1:0] SAT_LO = MIXV_W'(-(64'sd1 <<< (SB - 1)));

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_PREP     = 14'b00000000000010,
        S_READ     = 14'b00000000000100,
        S_FETCH    = 14'b00000000001000,
        S_DIV      = 14'b00000000010000,
        S_ROM_HEAD = 14'b00000000100000,
        S_ROM_TAIL = 14'b00000001000000,
        S_BL_TAIL  = 14'b00000010000000,
        S_BL_HEAD  = 14'b00000100000000,
        S_BL_SUM   = 14'b00001000000000,
        S_MIX_DIFF = 14'b00010000000000,
        S_MIX_MUL  = 14'b00100000000000,
        S_MIX_SUM  = 14'b01000000000000,
        S_LOAD     = 14'b10000000000000
    } state_t;

    function automatic logic signed [SB-1:0] saturate(input logic signed [MIXV_W-1:0] v);
        priority if (v > SAT_HI)
        begin
            return SAT_HI[SB-1:0];
        end
        else if (v < SAT_LO)
        begin
            return SAT_LO[SB-1:0];
        end
        else
        begin
            return v[SB-1:0];
        end
    endfunction

    // configuration registers
    logic [20:0]       loop_length_reg;
    logic [XF_W-1:0]   crossfade_len_reg;
    logic              linear_fade_reg;
    logic [GAIN_W-1:0] wet_mix_reg;
    logic              playback_enable_reg;
    logic [1:0]        loop_channels_reg;

    state_t            state_reg;
    state_t            state_next;
    logic              ch_reg;
    logic              out_valid_reg;
    logic [AW-1:0]     play_pos_reg;

    // per-tick working registers
    logic [LEN_W-1:0]         len_reg;
    logic [XF_W-1:0]          xf_reg;
    logic [AW-1:0]            pos_reg;
    logic [LEN_W-1:0]         base_reg;
    logic                     seam_reg;
    logic [XF_W-1:0]          k_reg;
    logic [IW-1:0]            idx_reg;
    logic [GAIN_W-1:0]        head_reg;
    logic [GAIN_W-1:0]        tail_reg;
    logic signed [SB-1:0]     dry_l_reg;
    logic signed [SB-1:0]     dry_r_reg;
    logic signed [SB-1:0]     a_l_reg;
    logic signed [SB-1:0]     a_r_reg;
    logic signed [WET_W-1:0]  wet_l_reg;
    logic signed [WET_W-1:0]  wet_r_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [MUL_B_W-1:0] diff_reg;
    logic signed [SB-1:0]     res_l_reg;
    logic signed [SB-1:0]     res_r_reg;
    logic                     res_seam_reg;
    clp_result_t              out_reg;

    // loop store
    logic [WORD_W-1:0] loop_mem [LOOP_DEPTH];
    logic [WORD_W-1:0] mem_q;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              item_acc;
    logic              load;
    logic              passthru;
    logic              stereo;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  half_len;
    logic [LEN_W-1:0]  top_pos;
    logic [XF_W-1:0]   xf;
    logic [AW-1:0]     restart_pos;
    logic [AW-1:0]     pos_eff;
    logic [AW-1:0]     pos_adv;
    logic [LEN_W-1:0]  pos_inc;
    logic [GAIN_W-1:0] mix;
    logic signed [SB-1:0] word_l;
    logic signed [SB-1:0] word_r;
    logic signed [SB-1:0] dry_ch;
    logic signed [WET_W-1:0] wet_ch;
    logic signed [SB-1:0] a_ch;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [BLEND_W-1:0] blend_sum;
    logic signed [PROD_W-1:0]  mix_rnd;
    logic signed [MIXV_W-1:0]  mix_v;

    logic              div_start;
    logic [DEN_W-1:0]  k_inc;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [QW-1:0]     div_q;

    logic              rom_rd;
    logic [IW-1:0]     rom_addr;
    logic [GAIN_W-1:0] rom_q;

    assign item_acc = item.valid && item.ready;
    assign item.ready = state_reg == S_IDLE;
    assign cfg.ready = 1'b1;
    assign load = (state_reg == S_LOAD) && (!out_valid_reg || result.ready);
    assign result.valid = out_valid_reg;
    assign result.payload = out_reg;

    // effective length, seam length and positions from the live registers
    always_comb
    begin
        if (32'(loop_length_reg) > 32'(LOOP_DEPTH))
        begin
            len = LEN_W'(LOOP_DEPTH);
        end
        else
        begin
            len = LEN_W'(loop_length_reg);
        end
        half_len = len >> 1;
        if (32'(crossfade_len_reg) < 32'(half_len))
        begin
            xf = crossfade_len_reg;
        end
        else
        begin
            xf = XF_W'(half_len);
        end
        top_pos = (len == '0) ? '0 : len - LEN_W'(1);
        if (32'(crossfade_len_reg) < 32'(top_pos))
        begin
            restart_pos = AW'(crossfade_len_reg);
        end
        else
        begin
            restart_pos = AW'(top_pos);
        end
    end

    assign passthru = !playback_enable_reg || (len == '0);
    assign stereo = loop_channels_reg >= 2'd2;
    assign mix = (32'(wet_mix_reg) > UNITY_Q15) ? GAIN_W'(UNITY_Q15) : wet_mix_reg;

    // a stale position wraps to the crossfade length, the loop's wrap point, before use
    assign pos_eff = (32'(play_pos_reg) >= 32'(len_reg)) ? AW'(xf_reg) : play_pos_reg;
    assign pos_inc = LEN_W'(pos_reg) + LEN_W'(1);
    assign pos_adv = (pos_inc >= len_reg) ? AW'(xf_reg) : AW'(pos_inc);

    // mono loop feeds the left sample to both channels
    assign word_l = mem_q[SB-1:0];
    assign word_r = stereo ? mem_q[WORD_W-1:SB] : mem_q[SB-1:0];
    assign dry_ch = ch_reg ? dry_r_reg : dry_l_reg;
    assign wet_ch = ch_reg ? wet_r_reg : wet_l_reg;
    assign a_ch = ch_reg ? a_r_reg : a_l_reg;

    assign mem_we = item_acc && (item.payload.cmd == CMD_WRITE)
                    && (32'(item.payload.write_addr) < 32'(LOOP_DEPTH));
    assign mem_waddr = AW'(item.payload.write_addr);
    assign mem_re = (state_reg == S_READ) || (state_reg == S_FETCH);
    assign mem_raddr = (state_reg == S_READ) ? pos_reg : AW'(k_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            loop_mem[mem_waddr] <= {item.payload.dry_right, item.payload.dry_left};
        end
        if (mem_re)
        begin
            mem_q <= loop_mem[mem_raddr];
        end
    end

    // gain position: (k+1) * 32768 or (k+1) * table depth over (xf + 1)
    assign k_inc = DEN_W'(k_reg) + DEN_W'(1);
    assign div_num = linear_fade_reg ? {k_inc, QW'(0)}
                                     : NUM_W'(k_inc) * NUM_W'(GAIN_TABLE_DEPTH);
    assign div_den = DEN_W'(xf_reg) + DEN_W'(1);
    assign div_start = (state_reg == S_FETCH) && seam_reg;

    clp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign rom_rd = ((state_reg == S_DIV) && div_done) || (state_reg == S_ROM_HEAD);
    assign rom_addr = (state_reg == S_ROM_HEAD) ? IW'(GAIN_TABLE_DEPTH - 1) - idx_reg
                                                : div_q[IW-1:0];

    clp_gain_rom #(
        .GAIN_TABLE_DEPTH (GAIN_TABLE_DEPTH)
    ) u_gain_rom (
        .clk  (clk),
        .rd   (rom_rd),
        .addr (rom_addr),
        .gain (rom_q)
    );

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_BL_TAIL:
            begin
                mul_a = {1'b0, tail_reg};
                mul_b = MUL_B_W'(a_ch);
            end
            S_BL_HEAD:
            begin
                mul_a = {1'b0, head_reg};
                mul_b = ch_reg ? MUL_B_W'(word_r) : MUL_B_W'(word_l);
            end
            S_MIX_MUL:
            begin
                mul_a = {1'b0, mix};
                mul_b = diff_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign blend_sum = BLEND_W'(acc_reg) + BLEND_W'(prod_reg) + BLEND_W'(16384);
    assign mix_rnd = prod_reg + PROD_W'(16384);
    assign mix_v = MIXV_W'(mix_rnd >>> 15) + MIXV_W'(dry_ch);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc && (item.payload.cmd == CMD_TICK))
                begin
                    state_next = passthru ? S_LOAD : S_PREP;
                end
            end
            S_PREP:     state_next = S_READ;
            S_READ:     state_next = S_FETCH;
            S_FETCH:    state_next = seam_reg ? S_DIV : S_MIX_DIFF;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = linear_fade_reg ? S_BL_TAIL : S_ROM_HEAD;
                end
            end
            S_ROM_HEAD: state_next = S_ROM_TAIL;
            S_ROM_TAIL: state_next = S_BL_TAIL;
            S_BL_TAIL:  state_next = S_BL_HEAD;
            S_BL_HEAD:  state_next = S_BL_SUM;
            S_BL_SUM:   state_next = ch_reg ? S_MIX_DIFF : S_BL_TAIL;
            S_MIX_DIFF: state_next = S_MIX_MUL;
            S_MIX_MUL:  state_next = S_MIX_SUM;
            S_MIX_SUM:  state_next = ch_reg ? S_LOAD : S_MIX_DIFF;
            S_LOAD:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            play_pos_reg <= '0;
            loop_length_reg <= '0;
            crossfade_len_reg <= '0;
            linear_fade_reg <= 1'b0;
            wet_mix_reg <= GAIN_W'(UNITY_Q15);
            playback_enable_reg <= 1'b0;
            loop_channels_reg <= 2'd2;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.payload.index)
                    REG_LOOP_LENGTH:     loop_length_reg <= cfg.payload.data;
                    REG_CROSSFADE_LEN:   crossfade_len_reg <= cfg.payload.data[XF_W-1:0];
                    REG_LINEAR_FADE:     linear_fade_reg <= cfg.payload.data[0];
                    REG_WET_MIX:         wet_mix_reg <= cfg.payload.data[GAIN_W-1:0];
                    REG_PLAYBACK_ENABLE: playback_enable_reg <= cfg.payload.data[0];
                    REG_LOOP_CHANNELS:   loop_channels_reg <= cfg.payload.data[1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (item_acc && (item.payload.cmd == CMD_RESTART))
            begin
                play_pos_reg <= restart_pos;
            end
            if ((state_reg == S_MIX_SUM) && ch_reg)
            begin
                play_pos_reg <= pos_adv;
            end
            if ((state_reg == S_BL_SUM) || (state_reg == S_MIX_SUM))
            begin
                ch_reg <= !ch_reg;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        unique case (state_reg)
            S_IDLE:
            begin
                len_reg <= len;
                xf_reg <= xf;
                dry_l_reg <= item.payload.dry_left;
                dry_r_reg <= item.payload.dry_right;
                res_l_reg <= item.payload.dry_left;
                res_r_reg <= item.payload.dry_right;
                res_seam_reg <= 1'b0;
            end
            S_PREP:
            begin
                pos_reg <= pos_eff;
                base_reg <= len_reg - LEN_W'(xf_reg);
            end
            S_READ:
            begin
                seam_reg <= (xf_reg != '0) && (LEN_W'(pos_reg) >= base_reg);
                k_reg <= XF_W'(LEN_W'(pos_reg) - base_reg);
            end
            S_FETCH:
            begin
                a_l_reg <= word_l;
                a_r_reg <= word_r;
                wet_l_reg <= WET_W'(word_l);
                wet_r_reg <= WET_W'(word_r);
                res_seam_reg <= seam_reg;
            end
            S_DIV:
            begin
                idx_reg <= div_q[IW-1:0];
                head_reg <= GAIN_W'(div_q);
                tail_reg <= GAIN_W'(UNITY_Q15) - GAIN_W'(div_q);
            end
            S_ROM_HEAD:
            begin
                head_reg <= rom_q;
            end
            S_ROM_TAIL:
            begin
                tail_reg <= rom_q;
            end
            S_BL_HEAD:
            begin
                acc_reg <= prod_reg;
            end
            S_BL_SUM:
            begin
                if (ch_reg)
                begin
                    wet_r_reg <= WET_W'(blend_sum >>> 15);
                end
                else
                begin
                    wet_l_reg <= WET_W'(blend_sum >>> 15);
                end
            end
            S_MIX_DIFF:
            begin
                diff_reg <= MUL_B_W'(wet_ch) - MUL_B_W'(dry_ch);
            end
            S_MIX_SUM:
            begin
                if (ch_reg)
                begin
                    res_r_reg <= saturate(mix_v);
                end
                else
                begin
                    res_l_reg <= saturate(mix_v);
                end
            end
            S_LOAD:
            begin
                if (load)
                begin
                    out_reg.out_left <= res_l_reg;
                    out_reg.out_right <= res_r_reg;
                    out_reg.in_seam <= res_seam_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
